FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the compensation pipeline RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BPC_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define BPC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/bpc_pkg.sv
// Types and constants shared by the barometric compensation pipeline.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CAL_W  = 16;   // calibration word
    localparam int RAW_W  = 24;   // raw conversion
    localparam int IDX_W  = 3;    // register index
    localparam int DT_W   = 25;   // D2 - C5 * 2^8
    localparam int TEMP_W = 20;   // temperature, 0.01 degC
    localparam int T2_W   = 18;   // dT^2 / 2^31
    localparam int OFF_W  = 40;   // offset, after second-order term
    localparam int SENS_W = 40;   // sensitivity, after second-order term
    localparam int OUT_W  = 32;   // result words

    localparam logic [IDX_W-1:0] IDX_PRESSURE_SENS   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_PRESSURE_OFFSET = 3'd1;
    localparam logic [IDX_W-1:0] IDX_SENS_TEMPCO     = 3'd2;
    localparam logic [IDX_W-1:0] IDX_OFFSET_TEMPCO   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_REF_TEMP        = 3'd4;
    localparam logic [IDX_W-1:0] IDX_TEMP_SENS       = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_REF = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW = -20'sd1500;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sens;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_sens;
    } cal_t;

    // First-order terms
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2;
    } first_t;

    // Fully compensated terms
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } comp_t;

endpackage

FILE: rtl/core/bpc_cfg.sv
// Calibration register file with a plain write port.
`timescale 1ns / 1ps

module bpc_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bpc_pkg::IDX_W-1:0] cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0] cfg_wdata,
    output bpc_pkg::cal_t             cal
);
    import bpc_pkg::*;

    cal_t cal_reg;
    cal_t cal_next;

    always_comb begin
        cal_next = cal_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                IDX_PRESSURE_SENS:   cal_next.pressure_sens   = cfg_wdata;
                IDX_PRESSURE_OFFSET: cal_next.pressure_offset = cfg_wdata;
                IDX_SENS_TEMPCO:     cal_next.sens_tempco     = cfg_wdata;
                IDX_OFFSET_TEMPCO:   cal_next.offset_tempco   = cfg_wdata;
                IDX_REF_TEMP:        cal_next.ref_temp        = cfg_wdata;
                IDX_TEMP_SENS:       cal_next.temp_sens       = cfg_wdata;
                default:             cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

FILE: rtl/core/bpc_coef.sv
// First-order stages: dT, the three dT products and dT squared, first-order terms.
`timescale 1ns / 1ps

module bpc_coef (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bpc_pkg::cal_t             cal,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bpc_pkg::RAW_W-1:0] in_d1,
    input  logic [bpc_pkg::RAW_W-1:0] in_d2,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bpc_pkg::first_t           out_data
);
    import bpc_pkg::*;

    localparam int STAGES    = 3;
    localparam int MW        = DT_W + CAL_W + 1;
    localparam int SQ_W      = 2 * DT_W;
    localparam int SH_TEMP   = 23;
    localparam int SH_OFF    = 7;
    localparam int SH_SENS   = 8;
    localparam int SH_T2     = 31;
    localparam logic [MW-1:0] BIAS_TEMP = MW'((64'd1 << SH_TEMP) - 64'd1);
    localparam logic [MW-1:0] BIAS_OFF  = MW'((64'd1 << SH_OFF) - 64'd1);
    localparam logic [MW-1:0] BIAS_SENS = MW'((64'd1 << SH_SENS) - 64'd1);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    logic [RAW_W-1:0]        a_d1_reg;
    logic signed [DT_W-1:0]  a_dt_reg;
    logic signed [DT_W-1:0]  a_dt_next;

    logic [RAW_W-1:0]        b_d1_reg;
    logic signed [MW-1:0]    b_m6_reg, b_m6_next;
    logic signed [MW-1:0]    b_m4_reg, b_m4_next;
    logic signed [MW-1:0]    b_m3_reg, b_m3_next;
    logic [T2_W-1:0]         b_t2_reg;
    logic signed [SQ_W-1:0]  sq_full;

    first_t                  c_data_reg;
    first_t                  c_data_next;
    logic [MW-1:0]           m6_b, m4_b, m3_b;

    // Stage advances when empty or when the stage after it advances
    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = c_data_reg;

    assign a_dt_next = $signed({1'b0, in_d2}) - $signed({1'b0, cal.ref_temp, 8'h00});

    always_comb begin
        b_m6_next = a_dt_reg * $signed({1'b0, cal.temp_sens});
        b_m4_next = a_dt_reg * $signed({1'b0, cal.offset_tempco});
        b_m3_next = a_dt_reg * $signed({1'b0, cal.sens_tempco});
        sq_full   = a_dt_reg * a_dt_reg;
    end

    // Divide by powers of two toward zero: bias negatives, then shift
    always_comb begin
        m6_b = b_m6_reg + (b_m6_reg[MW-1] ? BIAS_TEMP : '0);
        m4_b = b_m4_reg + (b_m4_reg[MW-1] ? BIAS_OFF : '0);
        m3_b = b_m3_reg + (b_m3_reg[MW-1] ? BIAS_SENS : '0);
        c_data_next.d1   = b_d1_reg;
        c_data_next.temp = TEMP_REF
            + {{(TEMP_W - MW + SH_TEMP){m6_b[MW-1]}}, m6_b[MW-1:SH_TEMP]};
        c_data_next.off  = {{(OFF_W - CAL_W - 16){1'b0}}, cal.pressure_offset, 16'h0000}
            + {{(OFF_W - MW + SH_OFF){m4_b[MW-1]}}, m4_b[MW-1:SH_OFF]};
        c_data_next.sens = {{(SENS_W - CAL_W - 15){1'b0}}, cal.pressure_sens, 15'h0000}
            + {{(SENS_W - MW + SH_SENS){m3_b[MW-1]}}, m3_b[MW-1:SH_SENS]};
        c_data_next.t2   = b_t2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a_d1_reg <= in_d1;
            a_dt_reg <= a_dt_next;
        end
        if (adv[1]) begin
            b_d1_reg <= a_d1_reg;
            b_m6_reg <= b_m6_next;
            b_m4_reg <= b_m4_next;
            b_m3_reg <= b_m3_next;
            b_t2_reg <= sq_full[SH_T2+T2_W-1:SH_T2];
        end
        if (adv[2]) begin
            c_data_reg <= c_data_next;
        end
    end

endmodule

FILE: rtl/core/bpc_corr.sv
// Second-order stages: cold and very-cold corrections to temp, offset and sensitivity.
`timescale 1ns / 1ps

module bpc_corr (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bpc_pkg::first_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bpc_pkg::comp_t  out_data
);
    import bpc_pkg::*;

    localparam int STAGES = 3;
    localparam int SQ_W   = 35;          // (TEMP - ref)^2 while below the ref
    localparam int C2_W   = SQ_W + 3;    // weighted squares and their sums

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    logic signed [TEMP_W-1:0]   dlo, dvl;
    logic signed [2*TEMP_W-1:0] sq_lo_full, sq_vl_full;

    first_t             d_data_reg;
    logic [SQ_W-1:0]    d_sq_lo_reg, d_sq_vl_reg;
    logic               d_lt_ref_reg, d_lt_low_reg;

    logic [C2_W-1:0]    sq_lo_x, sq_vl_x, five_lo, seven_vl, eleven_vl;
    first_t             e_data_reg;
    logic [C2_W-1:0]    e_off2_reg, e_off2_next;
    logic [C2_W-1:0]    e_sens2_reg, e_sens2_next;
    logic [T2_W-1:0]    e_t2_reg, e_t2_next;

    comp_t              f_data_reg, f_data_next;

    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_data  = f_data_reg;

    always_comb begin
        dlo        = in_data.temp - TEMP_REF;
        dvl        = in_data.temp - TEMP_LOW;
        sq_lo_full = dlo * dlo;
        sq_vl_full = dvl * dvl;
    end

    // Weight the squares by shift-add; drop them when not cold
    always_comb begin
        sq_lo_x   = C2_W'(d_sq_lo_reg);
        sq_vl_x   = C2_W'(d_sq_vl_reg);
        five_lo   = (sq_lo_x << 2) + sq_lo_x;
        seven_vl  = (sq_vl_x << 3) - sq_vl_x;
        eleven_vl = (sq_vl_x << 3) + (sq_vl_x << 1) + sq_vl_x;
        e_off2_next  = '0;
        e_sens2_next = '0;
        e_t2_next    = '0;
        if (d_lt_ref_reg) begin
            e_off2_next  = (five_lo >> 1) + (d_lt_low_reg ? seven_vl : '0);
            e_sens2_next = (five_lo >> 2) + (d_lt_low_reg ? (eleven_vl >> 1) : '0);
            e_t2_next    = d_data_reg.t2;
        end
    end

    always_comb begin
        f_data_next.d1   = e_data_reg.d1;
        f_data_next.temp = e_data_reg.temp - {{(TEMP_W - T2_W){1'b0}}, e_t2_reg};
        f_data_next.off  = e_data_reg.off - {{(OFF_W - C2_W){1'b0}}, e_off2_reg};
        f_data_next.sens = e_data_reg.sens - {{(SENS_W - C2_W){1'b0}}, e_sens2_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            d_data_reg   <= in_data;
            d_sq_lo_reg  <= sq_lo_full[SQ_W-1:0];
            d_sq_vl_reg  <= sq_vl_full[SQ_W-1:0];
            d_lt_ref_reg <= in_data.temp < TEMP_REF;
            d_lt_low_reg <= in_data.temp < TEMP_LOW;
        end
        if (adv[1]) begin
            e_data_reg  <= d_data_reg;
            e_off2_reg  <= e_off2_next;
            e_sens2_reg <= e_sens2_next;
            e_t2_reg    <= e_t2_next;
        end
        if (adv[2]) begin
            f_data_reg <= f_data_next;
        end
    end

endmodule

FILE: rtl/core/bpc_pres.sv
// Pressure stages: split D1 * SENS product, sum the partials, scale, subtract offset, scale into the output register.
`timescale 1ns / 1ps

module bpc_pres (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  bpc_pkg::comp_t                   in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [bpc_pkg::OUT_W-1:0] out_temp,
    output logic signed [bpc_pkg::OUT_W-1:0] out_pressure
);
    import bpc_pkg::*;

    localparam int STAGES = 5;
    localparam int LO_W   = 20;                  // low slice of SENS
    localparam int HI_W   = SENS_W - LO_W;       // signed high slice
    localparam int PL_W   = RAW_W + LO_W;
    localparam int PH_W   = RAW_W + HI_W + 1;
    localparam int PROD_W = 64;
    localparam int SH_P1  = 21;
    localparam int Q_W    = PROD_W - SH_P1;
    localparam int DIFF_W = Q_W + 1;
    localparam int SH_P2  = 15;
    localparam logic [PROD_W-1:0] BIAS_P1 = PROD_W'((64'd1 << SH_P1) - 64'd1);
    localparam logic [DIFF_W-1:0] BIAS_P2 = DIFF_W'((64'd1 << SH_P2) - 64'd1);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    logic [PL_W-1:0]          g_pl_reg, g_pl_next;
    logic signed [PH_W-1:0]   g_ph_reg, g_ph_next;
    logic signed [TEMP_W-1:0] g_temp_reg;
    logic signed [OFF_W-1:0]  g_off_reg;

    logic [PROD_W-1:0]        h_prod_reg, h_prod_next;
    logic signed [TEMP_W-1:0] h_temp_reg;
    logic signed [OFF_W-1:0]  h_off_reg;

    logic [PROD_W-1:0]        prod_b;
    logic [Q_W-1:0]           i_q_reg;
    logic signed [TEMP_W-1:0] i_temp_reg;
    logic signed [OFF_W-1:0]  i_off_reg;

    logic [DIFF_W-1:0]        j_diff_reg, j_diff_next;
    logic signed [TEMP_W-1:0] j_temp_reg;

    logic [DIFF_W-1:0]        diff_b;
    logic signed [OUT_W-1:0]  k_temp_reg, k_temp_next;
    logic signed [OUT_W-1:0]  k_pres_reg, k_pres_next;

    always_comb begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready     = adv[0];
    assign out_valid    = vld_reg[STAGES-1];
    assign out_temp     = k_temp_reg;
    assign out_pressure = k_pres_reg;

    always_comb begin
        g_pl_next = PL_W'(in_data.d1) * PL_W'(in_data.sens[LO_W-1:0]);
        g_ph_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[SENS_W-1:LO_W]);
    end

    // |D1 * SENS| < 2^63, so the high partial product fits PROD_W - LO_W bits
    assign h_prod_next = {g_ph_reg[PROD_W-LO_W-1:0], {LO_W{1'b0}}}
                       + {{(PROD_W - PL_W){1'b0}}, g_pl_reg};

    assign prod_b = h_prod_reg + (h_prod_reg[PROD_W-1] ? BIAS_P1 : '0);

    assign j_diff_next = {i_q_reg[Q_W-1], i_q_reg}
                       - {{(DIFF_W - OFF_W){i_off_reg[OFF_W-1]}}, i_off_reg};

    // Both results stay well inside 32 bits: sign-extend, no clamp is applied
    always_comb begin
        diff_b      = j_diff_reg + (j_diff_reg[DIFF_W-1] ? BIAS_P2 : '0);
        k_pres_next = {{(OUT_W - DIFF_W + SH_P2){diff_b[DIFF_W-1]}},
                       diff_b[DIFF_W-1:SH_P2]};
        k_temp_next = {{(OUT_W - TEMP_W){j_temp_reg[TEMP_W-1]}}, j_temp_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            g_pl_reg   <= g_pl_next;
            g_ph_reg   <= g_ph_next;
            g_temp_reg <= in_data.temp;
            g_off_reg  <= in_data.off;
        end
        if (adv[1]) begin
            h_prod_reg <= h_prod_next;
            h_temp_reg <= g_temp_reg;
            h_off_reg  <= g_off_reg;
        end
        if (adv[2]) begin
            i_q_reg    <= prod_b[PROD_W-1:SH_P1];
            i_temp_reg <= h_temp_reg;
            i_off_reg  <= h_off_reg;
        end
        if (adv[3]) begin
            j_diff_reg <= j_diff_next;
            j_temp_reg <= i_temp_reg;
        end
        if (adv[4]) begin
            k_temp_reg <= k_temp_next;
            k_pres_reg <= k_pres_next;
        end
    end

endmodule

FILE: rtl/core/baro_pressure_temp_compensation.sv
// Top level of the barometric pressure and temperature compensation pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Turns one raw pressure word (D1) and one raw temperature word (D2) into
// temperature in 0.01 degC and pressure in 0.01 mbar, using the six factory
// calibration words written through the cfg_* port (index 0..5, low 16 bits
// of cfg_wdata; other indexes are ignored; all words reset to zero). The
// second-order correction applies below 20.00 degC, with the extra term below
// -15.00 degC, both decided on the first-order temperature; every power-of-two
// division rounds toward zero. The datapath is an 11-stage pipeline that
// accepts one word every clock while m_ready stays high, and a word accepted
// on s_* passes through every stage to m_*. The depth is set by the chain
// of multipliers (dT products, squared temperature deltas, and the D1 * SENS
// product split into two partial products) with a register after each. Each
// stage holds its word when the stage after it is full and stalled, so s_ready
// drops only once every stage holds a word and m_valid waits on m_ready.
// Calibration words must be written only while the pipeline is empty.
module baro_pressure_temp_compensation (
    input  logic                             aclk,
    input  logic                             aresetn,
    // calibration write port
    input  logic                             cfg_wr_en,
    input  logic [bpc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]        cfg_wdata,
    // raw conversion words in
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bpc_pkg::RAW_W-1:0]        s_raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]        s_raw_temperature,
    // compensated words out
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [bpc_pkg::OUT_W-1:0] m_temp_centi_deg,
    output logic signed [bpc_pkg::OUT_W-1:0] m_pressure_centi_mbar
);
    import bpc_pkg::*;

    cal_t   cal;

    logic   coef_valid;
    logic   coef_ready;
    first_t coef_data;

    logic   corr_valid;
    logic   corr_ready;
    comp_t  corr_data;

    // Calibration words; the user must keep them static while words are in flight, the block does not enforce it
    bpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cal       (cal)
    );

    // Stages 1-3: dT, products with C6/C4/C3 and dT^2, first-order TEMP/OFF/SENS
    bpc_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cal       (cal),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_d1     (s_raw_pressure),
        .in_d2     (s_raw_temperature),
        .out_valid (coef_valid),
        .out_ready (coef_ready),
        .out_data  (coef_data)
    );

    // Stages 4-6: cold-range corrections T2, OFF2, SENS2
    bpc_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (coef_valid),
        .in_ready  (coef_ready),
        .in_data   (coef_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    // Stages 7-11: D1 * SENS / 2^21 - OFF, then / 2^15; last stage drives m_*
    bpc_pres u_pres (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (corr_valid),
        .in_ready     (corr_ready),
        .in_data      (corr_data),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_temp     (m_temp_centi_deg),
        .out_pressure (m_pressure_centi_mbar)
    );

    // Input backpressure only comes from a full pipeline stalled at the output
    `BPC_ASSERT_IMPL(a_stall_from_output, aclk, aresetn, !s_ready, m_valid && !m_ready)
    // Temperature never needs more than TEMP_W signed bits
    `BPC_ASSERT_IMPL(a_temp_range, aclk, aresetn, m_valid, m_temp_centi_deg[31:19] == '0 || m_temp_centi_deg[31:19] == '1)
    // Pressure stays within 29 signed bits, so the clamp is never needed
    `BPC_ASSERT_IMPL(a_pres_range, aclk, aresetn, m_valid, m_pressure_centi_mbar[31:28] == '0 || m_pressure_centi_mbar[31:28] == '1)
    // Writes past the last calibration word leave the words untouched
    `BPC_ASSERT_NEXT(a_cfg_ignore, aclk, aresetn, cfg_wr_en && (cfg_index > IDX_TEMP_SENS), $stable(cal))

endmodule
